// File: sv/pgmrb_pkg.sv
// Shared types, codes and constants of the polar grid min-radius binner.
package pgmrb_pkg;

   typedef enum logic [1:0] {
      CMD_ADD    = 2'd0,
      CMD_QPOINT = 2'd1,
      CMD_QINDEX = 2'd2
   } cmd_type;

   typedef enum logic [3:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_CHECK,
      ST_ITER,
      ST_SUM,
      ST_SQRT,
      ST_ADDR,
      ST_READ,
      ST_UPDATE
   } state_type;

   localparam int unsigned CSR_ADDR_W = 4;
   localparam logic [1:0] REG_ANGLE_STEPS  = 2'd0;
   localparam logic [1:0] REG_Z_STEPS      = 2'd1;
   localparam logic [1:0] REG_START_HEIGHT = 2'd2;
   localparam logic [1:0] REG_END_HEIGHT   = 2'd3;

   localparam logic [31:0] EMPTY_RADIUS = 32'hFFFF_FFFF;
   localparam logic [31:0] RADIUS_MAX   = 32'hFFFF_FFFE;
   localparam logic [31:0] HALF_TURN    = 32'h8000_0000;
   localparam logic [31:0] QUARTER_TURN = 32'h4000_0000;
   localparam int unsigned CORDIC_STEPS = 30;
   localparam int unsigned SQRT_STEPS   = 32;
   localparam int unsigned DIV_STEPS    = 8;

   typedef struct packed {
      logic [6:0]         angle_steps;
      logic [6:0]         z_steps;
      logic signed [31:0] start_height;
      logic signed [31:0] end_height;
   } cfg_type;

   typedef struct packed {
      logic clear;
      logic ready;
      logic capture;
      logic check;
      logic iter;
      logic sum_load;
      logic sqrt;
      logic lookup;
      logic read;
      logic update;
   } ctrl_cmd_type;

   typedef struct packed {
      logic clear_last;
      logic iter_last;
      logic sqrt_last;
      logic need_iter;
      logic is_add;
      logic out_free;
   } ctrl_status_type;

   // atan(2^-i) in turns scaled by 2^32
   function automatic logic [30:0] atan_turn(input logic [4:0] idx);
      logic [30:0] v;
      unique case (idx)
         5'd0:  v = 31'd536870912;
         5'd1:  v = 31'd316933406;
         5'd2:  v = 31'd167458907;
         5'd3:  v = 31'd85004756;
         5'd4:  v = 31'd42667331;
         5'd5:  v = 31'd21354465;
         5'd6:  v = 31'd10679838;
         5'd7:  v = 31'd5340245;
         5'd8:  v = 31'd2670163;
         5'd9:  v = 31'd1335087;
         5'd10: v = 31'd667544;
         5'd11: v = 31'd333772;
         5'd12: v = 31'd166886;
         5'd13: v = 31'd83443;
         5'd14: v = 31'd41722;
         5'd15: v = 31'd20861;
         5'd16: v = 31'd10430;
         5'd17: v = 31'd5215;
         5'd18: v = 31'd2608;
         5'd19: v = 31'd1304;
         5'd20: v = 31'd652;
         5'd21: v = 31'd326;
         5'd22: v = 31'd163;
         5'd23: v = 31'd81;
         5'd24: v = 31'd41;
         5'd25: v = 31'd20;
         5'd26: v = 31'd10;
         5'd27: v = 31'd5;
         5'd28: v = 31'd3;
         5'd29: v = 31'd1;
         default: v = 31'd0;
      endcase
      return v;
   endfunction

endpackage

// File: sv/pgmrb_req_if.sv
// Command channel: one beat carries a command, a point and slot indices.
interface pgmrb_req_if #(parameter int COORD_WIDTH = 32) ();
   logic                          valid;
   logic                          ready;
   logic [1:0]                    cmd;
   logic signed [COORD_WIDTH-1:0] point_x;
   logic signed [COORD_WIDTH-1:0] point_y;
   logic signed [COORD_WIDTH-1:0] point_z;
   logic [5:0]                    angle_index;
   logic [5:0]                    height_index;

   modport source (output valid, cmd, point_x, point_y, point_z, angle_index, height_index,
                   input ready);
   modport sink (input valid, cmd, point_x, point_y, point_z, angle_index, height_index,
                 output ready);
endinterface

// File: sv/pgmrb_rsp_if.sv
// Result channel: one beat carries hit, bin radius and bin index.
interface pgmrb_rsp_if ();
   logic        valid;
   logic        ready;
   logic        hit;
   logic [31:0] radius;
   logic [11:0] bin_index;

   modport source (output valid, hit, radius, bin_index, input ready);
   modport sink (input valid, hit, radius, bin_index, output ready);
endinterface

// File: sv/polar_grid_min_radius_binner.sv
// Top level of the polar grid min-radius binner.
//
//   channel   direction  handshake                payload
//   req_bus   in         valid/ready              cmd, point_x/y/z, angle/height index
//   rsp_bus   out        valid/ready              hit, radius, bin_index
//   csr       in         psel/penable/pwrite      paddr, pwdata (prdata read back)
//
// An add runs the CORDIC, squaring and height divider side by side in one shared iteration
// window, then a bit-serial square root runs before the store lookup, read and update.
// A point query skips the root; an index query or an out-of-range point also skips the
// iteration window.
// After reset the store is swept to empty, one bin a cycle, before the first beat is
// taken.
// A finished result waits in the output register while the next beat is taken in.
module polar_grid_min_radius_binner
   import pgmrb_pkg::*;
#(
   parameter int MAX_ANGLE_SLOTS  = 64,
   parameter int MAX_HEIGHT_SLOTS = 64,
   parameter int COORD_WIDTH      = 32
) (
   input  logic                  clock,
   input  logic                  reset,
   pgmrb_req_if.sink             req_bus,
   pgmrb_rsp_if.source           rsp_bus,
   input  logic                  psel,
   input  logic                  penable,
   input  logic                  pwrite,
   input  logic [CSR_ADDR_W-1:0] paddr,
   input  logic [31:0]           pwdata,
   output logic [31:0]           prdata,
   output logic                  pready
);
   cfg_type         cfg;
   ctrl_cmd_type    ctrl;
   ctrl_status_type status;

   pgmrb_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready),
      .cfg     (cfg)
   );

   pgmrb_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_bus.valid),
      .status    (status),
      .ctrl      (ctrl)
   );

   assign req_bus.ready = ctrl.ready;

   pgmrb_dp #(
      .MAX_ANGLE_SLOTS  (MAX_ANGLE_SLOTS),
      .MAX_HEIGHT_SLOTS (MAX_HEIGHT_SLOTS),
      .COORD_WIDTH      (COORD_WIDTH)
   ) u_dp (
      .clock      (clock),
      .reset      (reset),
      .ctrl       (ctrl),
      .status     (status),
      .cfg        (cfg),
      .req_cmd    (req_bus.cmd),
      .req_x      (req_bus.point_x),
      .req_y      (req_bus.point_y),
      .req_z      (req_bus.point_z),
      .req_ai     (req_bus.angle_index),
      .req_hi     (req_bus.height_index),
      .rsp_ready  (rsp_bus.ready),
      .rsp_valid  (rsp_bus.valid),
      .rsp_hit    (rsp_bus.hit),
      .rsp_radius (rsp_bus.radius),
      .rsp_bin    (rsp_bus.bin_index)
   );
endmodule

// File: sv/pgmrb_ram.sv
// Generic single-write, single-read RAM with registered read data.
module pgmrb_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 4096
) (
   input  logic                                          clock,
   input  logic                                          we,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0]  waddr,
   input  logic [WIDTH-1:0]                              wdata,
   input  logic                                          re,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0]  raddr,
   output logic [WIDTH-1:0]                              rdata_ff
);
   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      if (re) begin
         rdata_ff <= mem_ff[raddr];
      end
   end
endmodule

// File: sv/pgmrb_csr.sv
// Configuration registers behind the APB-style port.
module pgmrb_csr
   import pgmrb_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  psel,
   input  logic                  penable,
   input  logic                  pwrite,
   input  logic [CSR_ADDR_W-1:0] paddr,
   input  logic [31:0]           pwdata,
   output logic [31:0]           prdata,
   output logic                  pready,
   output cfg_type               cfg
);
   cfg_type cfg_ff, cfg_in;
   logic    wr_en;

   assign pready = 1'b1;
   assign wr_en  = psel & penable & pwrite;
   assign cfg    = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         unique case (paddr[3:2])
            REG_ANGLE_STEPS:  cfg_in.angle_steps  = pwdata[6:0];
            REG_Z_STEPS:      cfg_in.z_steps      = pwdata[6:0];
            REG_START_HEIGHT: cfg_in.start_height = $signed(pwdata);
            REG_END_HEIGHT:   cfg_in.end_height   = $signed(pwdata);
            default:          cfg_in = cfg_ff;
         endcase
      end
   end

   always_comb begin
      unique case (paddr[3:2])
         REG_ANGLE_STEPS:  prdata = {25'd0, cfg_ff.angle_steps};
         REG_Z_STEPS:      prdata = {25'd0, cfg_ff.z_steps};
         REG_START_HEIGHT: prdata = cfg_ff.start_height;
         REG_END_HEIGHT:   prdata = cfg_ff.end_height;
         default:          prdata = 32'd0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.angle_steps  <= 7'd64;
         cfg_ff.z_steps      <= 7'd64;
         cfg_ff.start_height <= 32'sd0;
         cfg_ff.end_height   <= 32'sd65536;
      end else begin
         cfg_ff <= cfg_in;
      end
   end
endmodule

// File: sv/pgmrb_ctrl.sv
// Sequencer: steps one command through check, iterations, lookup and update.
module pgmrb_ctrl
   import pgmrb_pkg::*;
(
   input  logic            clock,
   input  logic            reset,
   input  logic            req_valid,
   input  ctrl_status_type status,
   output ctrl_cmd_type    ctrl
);
   state_type state_ff, state_in;

   always_comb begin
      state_in = state_ff;
      ctrl     = '0;
      unique case (state_ff)
         ST_CLEAR: begin
            ctrl.clear = 1'b1;
            if (status.clear_last) state_in = ST_IDLE;
         end
         ST_IDLE: begin
            ctrl.ready = 1'b1;
            if (req_valid) begin
               ctrl.capture = 1'b1;
               state_in     = ST_CHECK;
            end
         end
         ST_CHECK: begin
            ctrl.check = 1'b1;
            state_in   = status.need_iter ? ST_ITER : ST_ADDR;
         end
         ST_ITER: begin
            ctrl.iter = 1'b1;
            if (status.iter_last) state_in = status.is_add ? ST_SUM : ST_ADDR;
         end
         ST_SUM: begin
            ctrl.sum_load = 1'b1;
            state_in      = ST_SQRT;
         end
         ST_SQRT: begin
            ctrl.sqrt = 1'b1;
            if (status.sqrt_last) state_in = ST_ADDR;
         end
         ST_ADDR: begin
            ctrl.lookup = 1'b1;
            state_in    = ST_READ;
         end
         ST_READ: begin
            ctrl.read = 1'b1;
            state_in  = ST_UPDATE;
         end
         ST_UPDATE: begin
            // hold until the output register is free
            if (status.out_free) begin
               ctrl.update = 1'b1;
               state_in    = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end
endmodule

// File: sv/pgmrb_dp.sv
// Datapath: height check, CORDIC angle, bit-serial squares, root, divider, store access.
module pgmrb_dp
   import pgmrb_pkg::*;
#(
   parameter int MAX_ANGLE_SLOTS  = 64,
   parameter int MAX_HEIGHT_SLOTS = 64,
   parameter int COORD_WIDTH      = 32
) (
   input  logic                          clock,
   input  logic                          reset,
   input  ctrl_cmd_type                  ctrl,
   output ctrl_status_type               status,
   input  cfg_type                       cfg,
   input  logic [1:0]                    req_cmd,
   input  logic signed [COORD_WIDTH-1:0] req_x,
   input  logic signed [COORD_WIDTH-1:0] req_y,
   input  logic signed [COORD_WIDTH-1:0] req_z,
   input  logic [5:0]                    req_ai,
   input  logic [5:0]                    req_hi,
   input  logic                          rsp_ready,
   output logic                          rsp_valid,
   output logic                          rsp_hit,
   output logic [31:0]                   rsp_radius,
   output logic [11:0]                   rsp_bin
);
   localparam int W        = COORD_WIDTH;
   localparam int CW       = W + 3;
   localparam int DW       = ((W > 32) ? W : 32) + 1;
   localparam int PW       = DW + 9;
   localparam int DEPTH    = MAX_ANGLE_SLOTS * MAX_HEIGHT_SLOTS;
   localparam int AW       = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int ITER_LEN = (W > CORDIC_STEPS) ? W : CORDIC_STEPS;

   // captured beat
   logic [1:0]          cmd_ff, cmd_in;
   logic signed [W-1:0] x_ff, x_in, y_ff, y_in, z_ff, z_in;
   logic [5:0]          ai_ff, ai_in, hi_ff, hi_in;
   // height and divider
   logic                in_range_ff, in_range_in;
   logic signed [PW-1:0] rem_ff, rem_in, dd_ff, dd_in;
   logic [7:0]          q_ff, q_in;
   // CORDIC
   logic                axis_ff, axis_in;
   logic signed [CW-1:0] cx_ff, cx_in, cy_ff, cy_in;
   logic signed [32:0]  cz_ff, cz_in;
   logic [31:0]         base_ff, base_in;
   // squares
   logic [63:0]         mcx_ff, mcx_in, mcy_ff, mcy_in, accx_ff, accx_in, accy_ff, accy_in;
   logic [W-1:0]        mpx_ff, mpx_in, mpy_ff, mpy_in;
   // root
   logic [63:0]         sum_ff, sum_in;
   logic [33:0]         srem_ff, srem_in;
   logic [31:0]         root_ff, root_in;
   // counters and lookup
   logic [5:0]          step_ff, step_in;
   logic [AW-1:0]       clr_ff, clr_in;
   logic                hit_ff, hit_in;
   logic [13:0]         bin_ff, bin_in;
   // output register
   logic                rv_ff, rv_in, rh_ff, rh_in;
   logic [31:0]         rr_ff, rr_in;
   logic [11:0]         rb_ff, rb_in;

   // comb helpers
   logic [6:0]          na, nz;
   logic signed [DW-1:0] zz, ss, ee, dd, zms, zme;
   logic signed [PW-1:0] nsz, num;
   logic signed [CW-1:0] xe, ye, x1, y1, xs, ys, ux;
   logic [31:0]         b1, angle, zc;
   logic [2:0]          div_sh;
   logic signed [PW-1:0] dsh;
   logic [33:0]         srem_t, trial;
   logic [7:0]          nm1, hslot;
   logic [38:0]         aprod;
   logic [13:0]         bin_c;
   logic                hit_c;
   logic [31:0]         rad, radius_new;
   logic                wr_ok, ram_we;
   logic [AW-1:0]       ram_waddr;
   logic [31:0]         ram_wdata, ram_rdata;

   always_comb begin
      if (cfg.angle_steps == 7'd0)                     na = 7'd1;
      else if (32'(cfg.angle_steps) > MAX_ANGLE_SLOTS) na = 7'(MAX_ANGLE_SLOTS);
      else                                             na = cfg.angle_steps;
      if (cfg.z_steps == 7'd0)                         nz = 7'd1;
      else if (32'(cfg.z_steps) > MAX_HEIGHT_SLOTS)    nz = 7'(MAX_HEIGHT_SLOTS);
      else                                             nz = cfg.z_steps;
   end

   // height range and slot numerator
   always_comb begin
      zz  = DW'(z_ff);
      ss  = DW'(cfg.start_height);
      ee  = DW'(cfg.end_height);
      dd  = ee - ss;
      zms = zz - ss;
      zme = zz - ee;
      nsz = $signed(PW'(nz));
      num = PW'(zms) * nsz;
   end

   // fold the vector into the upper half-plane
   always_comb begin
      xe = CW'(x_ff);
      ye = CW'(y_ff);
      ux = (xe < 0) ? -xe : xe;
      if (ye < 0) begin
         x1 = -xe;
         y1 = -ye;
         b1 = HALF_TURN;
      end else begin
         x1 = xe;
         y1 = ye;
         b1 = 32'd0;
      end
   end

   always_comb begin
      xs     = cx_ff >>> step_ff;
      ys     = cy_ff >>> step_ff;
      div_sh = 3'(3'd7 - step_ff[2:0]);
      dsh    = dd_ff <<< div_sh;
      srem_t = {srem_ff[31:0], sum_ff[63:62]};
      trial  = {root_ff, 2'b01};
      nm1    = {1'b0, nz} - 8'd1;
      hslot  = (q_ff > nm1) ? nm1 : q_ff;
      if (cz_ff < 0)                             zc = 32'd0;
      else if (cz_ff > $signed({1'b0, QUARTER_TURN - 32'd1})) zc = QUARTER_TURN - 32'd1;
      else                                       zc = cz_ff[31:0];
      angle  = base_ff + zc;
      aprod  = angle * na;
      hit_c  = 1'b0;
      bin_c  = 14'd0;
      case (cmd_ff) inside
         CMD_ADD, CMD_QPOINT: begin
            bin_c = 14'(hslot) * 14'(na) + 14'(aprod[38:32]);
            hit_c = in_range_ff && (32'(bin_c) < DEPTH);
         end
         CMD_QINDEX: begin
            bin_c = 14'(hi_ff) * 14'(na) + 14'(ai_ff);
            hit_c = ({1'b0, ai_ff} < na) && ({1'b0, hi_ff} < nz) && (32'(bin_c) < DEPTH);
         end
         default: begin
            hit_c = 1'b0;
         end
      endcase
      rad        = (root_ff == EMPTY_RADIUS) ? RADIUS_MAX : root_ff;
      wr_ok      = hit_ff && (cmd_ff == CMD_ADD) && (rad < ram_rdata);
      radius_new = !hit_ff ? EMPTY_RADIUS : (wr_ok ? rad : ram_rdata);
   end

   always_comb begin
      cmd_in = cmd_ff; x_in = x_ff; y_in = y_ff; z_in = z_ff; ai_in = ai_ff; hi_in = hi_ff;
      in_range_in = in_range_ff; rem_in = rem_ff; dd_in = dd_ff; q_in = q_ff;
      axis_in = axis_ff; cx_in = cx_ff; cy_in = cy_ff; cz_in = cz_ff; base_in = base_ff;
      mcx_in = mcx_ff; mcy_in = mcy_ff; accx_in = accx_ff; accy_in = accy_ff;
      mpx_in = mpx_ff; mpy_in = mpy_ff;
      sum_in = sum_ff; srem_in = srem_ff; root_in = root_ff;
      step_in = step_ff; clr_in = clr_ff; hit_in = hit_ff; bin_in = bin_ff;
      rv_in = rv_ff; rh_in = rh_ff; rr_in = rr_ff; rb_in = rb_ff;

      if (rv_ff && rsp_ready) rv_in = 1'b0;
      if (ctrl.clear) clr_in = clr_ff + AW'(1);

      if (ctrl.capture) begin
         cmd_in = req_cmd; x_in = req_x; y_in = req_y; z_in = req_z;
         ai_in = req_ai; hi_in = req_hi;
      end

      if (ctrl.check) begin
         in_range_in = (dd > 0) && ((PW'(zms) * (nsz <<< 1) + PW'(dd)) >= 0)
                       && ((PW'(zme) * (nsz <<< 1)) <= PW'(dd));
         rem_in  = (num < 0) ? '0 : num;
         dd_in   = PW'(dd);
         q_in    = 8'd0;
         step_in = 6'd0;
         cz_in   = 33'sd0;
         axis_in = (ye == 0);
         if (ye == 0) begin
            base_in = (xe >= 0) ? 32'd0 : HALF_TURN;
            cx_in   = xe;
            cy_in   = ye;
         end else if (x1 <= 0) begin
            cx_in   = y1;
            cy_in   = -x1;
            base_in = b1 + QUARTER_TURN;
         end else begin
            cx_in   = x1;
            cy_in   = y1;
            base_in = b1;
         end
         mcx_in  = 64'(unsigned'(ux));
         mpx_in  = W'(ux);
         accx_in = 64'd0;
         mcy_in  = 64'(unsigned'((ye < 0) ? -ye : ye));
         mpy_in  = W'((ye < 0) ? -ye : ye);
         accy_in = 64'd0;
      end

      if (ctrl.iter) begin
         step_in = step_ff + 6'd1;
         if (mpx_ff[0]) accx_in = accx_ff + mcx_ff;
         if (mpy_ff[0]) accy_in = accy_ff + mcy_ff;
         mcx_in = mcx_ff << 1;
         mcy_in = mcy_ff << 1;
         mpx_in = mpx_ff >> 1;
         mpy_in = mpy_ff >> 1;
         if (!axis_ff && (32'(step_ff) < CORDIC_STEPS)) begin
            if (cy_ff >= 0) begin
               cx_in = cx_ff + ys;
               cy_in = cy_ff - xs;
               cz_in = cz_ff + $signed({2'b00, atan_turn(step_ff[4:0])});
            end else begin
               cx_in = cx_ff - ys;
               cy_in = cy_ff + xs;
               cz_in = cz_ff - $signed({2'b00, atan_turn(step_ff[4:0])});
            end
         end
         if (32'(step_ff) < DIV_STEPS) begin
            if (rem_ff >= dsh) begin
               rem_in = rem_ff - dsh;
               q_in   = {q_ff[6:0], 1'b1};
            end else begin
               q_in   = {q_ff[6:0], 1'b0};
            end
         end
      end

      if (ctrl.sum_load) begin
         sum_in  = accx_ff + accy_ff;
         srem_in = 34'd0;
         root_in = 32'd0;
         step_in = 6'd0;
      end

      if (ctrl.sqrt) begin
         step_in = step_ff + 6'd1;
         sum_in  = sum_ff << 2;
         if (srem_t >= trial) begin
            srem_in = srem_t - trial;
            root_in = {root_ff[30:0], 1'b1};
         end else begin
            srem_in = srem_t;
            root_in = {root_ff[30:0], 1'b0};
         end
      end

      if (ctrl.lookup) begin
         hit_in = hit_c;
         bin_in = bin_c;
      end

      if (ctrl.update) begin
         rv_in = 1'b1;
         rh_in = hit_ff;
         rr_in = radius_new;
         rb_in = hit_ff ? bin_ff[11:0] : 12'd0;
      end
   end

   assign ram_we    = ctrl.clear | (ctrl.update & wr_ok);
   assign ram_waddr = ctrl.clear ? clr_ff : AW'(bin_ff);
   assign ram_wdata = ctrl.clear ? EMPTY_RADIUS : rad;

   pgmrb_ram #(.WIDTH(32), .DEPTH(DEPTH)) u_store (
      .clock    (clock),
      .we       (ram_we),
      .waddr    (ram_waddr),
      .wdata    (ram_wdata),
      .re       (ctrl.read),
      .raddr    (AW'(bin_ff)),
      .rdata_ff (ram_rdata)
   );

   assign status.clear_last = (clr_ff == AW'(DEPTH - 1));
   assign status.iter_last  = (step_ff == 6'(ITER_LEN - 1));
   assign status.sqrt_last  = (step_ff == 6'(SQRT_STEPS - 1));
   assign status.need_iter  = ((cmd_ff == CMD_ADD) || (cmd_ff == CMD_QPOINT)) && in_range_in;
   assign status.is_add     = (cmd_ff == CMD_ADD);
   assign status.out_free   = !rv_ff || rsp_ready;

   assign rsp_valid  = rv_ff;
   assign rsp_hit    = rh_ff;
   assign rsp_radius = rr_ff;
   assign rsp_bin    = rb_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rv_ff   <= 1'b0;
         clr_ff  <= '0;
         step_ff <= 6'd0;
      end else begin
         rv_ff   <= rv_in;
         clr_ff  <= clr_in;
         step_ff <= step_in;
      end
   end

   always_ff @(posedge clock) begin
      cmd_ff <= cmd_in; x_ff <= x_in; y_ff <= y_in; z_ff <= z_in;
      ai_ff <= ai_in; hi_ff <= hi_in;
      in_range_ff <= in_range_in; rem_ff <= rem_in; dd_ff <= dd_in; q_ff <= q_in;
      axis_ff <= axis_in; cx_ff <= cx_in; cy_ff <= cy_in; cz_ff <= cz_in; base_ff <= base_in;
      mcx_ff <= mcx_in; mcy_ff <= mcy_in; accx_ff <= accx_in; accy_ff <= accy_in;
      mpx_ff <= mpx_in; mpy_ff <= mpy_in;
      sum_ff <= sum_in; srem_ff <= srem_in; root_ff <= root_in;
      hit_ff <= hit_in; bin_ff <= bin_in;
      rh_ff <= rh_in; rr_ff <= rr_in; rb_ff <= rb_in;
   end
endmodule
